[design/trp_pkg.sv]
package trp_pkg;

    // Field widths shared by the datapath modules.
    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 31;
    localparam int CFG_IDX_W = 3;

    // Serial multiplier: signed operands, two multiplier bits retired per cycle.
    localparam int MUL_W     = 34;
    localparam int MUL_STEPS = MUL_W / 2;
    localparam int PROD_W    = 2 * MUL_W;

    typedef logic signed [MUL_W-1:0]  trp_mul_op_t;
    typedef logic signed [PROD_W-1:0] trp_prod_t;
    typedef logic signed [DATA_W-1:0] trp_word_t;

    // Saturation bounds of a 32-bit signed word, held at product width.
    localparam trp_prod_t S32_MAX_EXT = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
    localparam trp_prod_t S32_MIN_EXT = {{(PROD_W-31){1'b1}}, {31{1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 31'd65;
    localparam logic [PERIOD_W-1:0] INTEG_LIMIT_RST = 31'd65536;

endpackage

[design/three_axis_rate_pid_unit.sv]
// Body-rate PID for roll, pitch and yaw, one axis after another on a shared datapath.
// Each axis runs four radix-4 Booth multiplies in turn on the shared multiplier; the
// divider for the derivative, with a (33 + FRAC_BITS)-bit numerator, runs alongside them.
// No new item is taken until the result has moved to the output register and the
// block is back in idle; in_stall stays high until then.
// Reset: integrals and previous measurements clear to zero, gains to zero,
// step_period to 65 and integ_limit to 65536 (1.0 at the default FRAC_BITS).
module three_axis_rate_pid_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [trp_pkg::DATA_W-1:0]   want_roll,
    input  logic signed [trp_pkg::DATA_W-1:0]   want_pitch,
    input  logic signed [trp_pkg::DATA_W-1:0]   want_yaw,
    input  logic signed [trp_pkg::DATA_W-1:0]   meas_roll,
    input  logic signed [trp_pkg::DATA_W-1:0]   meas_pitch,
    input  logic signed [trp_pkg::DATA_W-1:0]   meas_yaw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [trp_pkg::DATA_W-1:0]   torque_roll,
    output logic signed [trp_pkg::DATA_W-1:0]   torque_pitch,
    output logic signed [trp_pkg::DATA_W-1:0]   torque_yaw,
    input  logic                                cfg_we,
    input  logic [trp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [trp_pkg::DATA_W-1:0]          cfg_data
);

    localparam int DIV_NUM_W = 33 + FRAC_BITS;
    localparam int PROD_W    = trp_pkg::PROD_W;
    localparam int PERIOD_W  = trp_pkg::PERIOD_W;
    localparam logic [1:0] AX_FIRST = 2'd0;
    localparam logic [1:0] AX_LAST  = 2'd2;

    localparam logic [DIV_NUM_W-1:0] QUO_POS_MAX = {{(DIV_NUM_W-31){1'b0}}, {31{1'b1}}};
    localparam logic [DIV_NUM_W-1:0] QUO_NEG_MAX =
        {{(DIV_NUM_W-32){1'b0}}, 1'b1, {31{1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_START,
        ST_LAUNCH,
        ST_W_INC,
        ST_CLAMP,
        ST_W_P,
        ST_W_I,
        ST_W_DIV,
        ST_W_D,
        ST_SAT,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [1:0]              ax_reg;
    logic                    mul_start_reg;
    logic                    div_start_reg;
    logic                    out_valid_reg;

    // Configuration registers.
    trp_pkg::trp_word_t      gain_prop_reg;
    trp_pkg::trp_word_t      gain_integ_reg;
    trp_pkg::trp_word_t      gain_deriv_reg;
    logic [PERIOD_W-1:0]     step_period_reg;
    logic [PERIOD_W-1:0]     integ_limit_reg;

    // Controller state kept per axis.
    trp_pkg::trp_word_t      integ_reg [0:2];
    trp_pkg::trp_word_t      prev_reg  [0:2];

    // Payload registers.
    trp_pkg::trp_word_t      want_reg  [0:2];
    trp_pkg::trp_word_t      meas_reg  [0:2];
    trp_pkg::trp_word_t      tq_reg    [0:2];
    trp_pkg::trp_word_t      torque_reg [0:2];
    logic signed [32:0]      err_reg;
    logic signed [32:0]      diff_reg;
    logic [DIV_NUM_W-1:0]    div_num_reg;
    logic                    div_neg_reg;
    trp_pkg::trp_prod_t      acc_reg;
    trp_pkg::trp_prod_t      tsum_reg;
    trp_pkg::trp_mul_op_t    mul_a_reg;
    trp_pkg::trp_mul_op_t    mul_b_reg;

    // Unit connections and datapath nets.
    logic                    mul_done;
    trp_pkg::trp_prod_t      mul_prod;
    logic                    div_busy;
    logic [DIV_NUM_W-1:0]    div_quo;
    logic                    out_free;

    trp_pkg::trp_prod_t      prod_shift;
    trp_pkg::trp_prod_t      integ_ext;
    trp_pkg::trp_prod_t      lim_pos;
    trp_pkg::trp_prod_t      lim_neg;
    trp_pkg::trp_word_t      acc_clamped;
    trp_pkg::trp_word_t      tsum_sat;
    logic [32:0]             diff_mag;
    logic [DIV_NUM_W-1:0]    quo_neg;
    trp_pkg::trp_word_t      deriv;

    // Shared serial multiplier and derivative divider.
    trp_booth_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    trp_serial_div #(
        .NUM_W (DIV_NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (step_period_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // Scaling, clamping and saturation of the current axis.
    always_comb
    begin
        prod_shift = mul_prod >>> FRAC_BITS;
        integ_ext  = {{(PROD_W-32){integ_reg[ax_reg][31]}}, integ_reg[ax_reg]};
        lim_pos    = {{(PROD_W-PERIOD_W){1'b0}}, integ_limit_reg};
        lim_neg    = -lim_pos;

        if (acc_reg > lim_pos)
        begin
            acc_clamped = lim_pos[31:0];
        end
        else if (acc_reg < lim_neg)
        begin
            acc_clamped = lim_neg[31:0];
        end
        else
        begin
            acc_clamped = acc_reg[31:0];
        end

        if (tsum_reg > trp_pkg::S32_MAX_EXT)
        begin
            tsum_sat = trp_pkg::S32_MAX_EXT[31:0];
        end
        else if (tsum_reg < trp_pkg::S32_MIN_EXT)
        begin
            tsum_sat = trp_pkg::S32_MIN_EXT[31:0];
        end
        else
        begin
            tsum_sat = tsum_reg[31:0];
        end
    end

    // Derivative numerator magnitude; signed, saturated quotient, zero if step_period is 0.
    always_comb
    begin
        diff_mag = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);
        quo_neg  = -div_quo;
        if (step_period_reg == '0)
        begin
            deriv = '0;
        end
        else if (div_neg_reg)
        begin
            deriv = (div_quo > QUO_NEG_MAX) ? trp_pkg::S32_MIN_EXT[31:0] : quo_neg[31:0];
        end
        else
        begin
            deriv = (div_quo > QUO_POS_MAX) ? trp_pkg::S32_MAX_EXT[31:0] : div_quo[31:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_deriv_reg  <= '0;
            step_period_reg <= trp_pkg::STEP_PERIOD_RST;
            integ_limit_reg <= trp_pkg::INTEG_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trp_pkg::REG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                trp_pkg::REG_GAIN_INTEG:  gain_integ_reg  <= cfg_data;
                trp_pkg::REG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                trp_pkg::REG_STEP_PERIOD: step_period_reg <= cfg_data[PERIOD_W-1:0];
                trp_pkg::REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[PERIOD_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Sequencer: walks the three axes through increment, clamp and the three gain terms.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_reg        <= AX_FIRST;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            // A new result is raised as the old one leaves or once the slot is empty.
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        ax_reg    <= AX_FIRST;
                        state_reg <= ST_AX_START;
                    end
                end
                ST_AX_START:
                begin
                    state_reg <= ST_LAUNCH;
                end
                ST_LAUNCH:
                begin
                    mul_start_reg <= 1'b1;
                    div_start_reg <= 1'b1;
                    state_reg     <= ST_W_INC;
                end
                ST_W_INC:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP:
                begin
                    integ_reg[ax_reg] <= acc_clamped;
                    mul_start_reg     <= 1'b1;
                    state_reg         <= ST_W_P;
                end
                ST_W_P:
                begin
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_W_I;
                    end
                end
                ST_W_I:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_W_DIV;
                    end
                end
                ST_W_DIV:
                begin
                    if (!div_busy)
                    begin
                        prev_reg[ax_reg] <= meas_reg[ax_reg];
                        mul_start_reg    <= 1'b1;
                        state_reg        <= ST_W_D;
                    end
                end
                ST_W_D:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT:
                begin
                    if (ax_reg == AX_LAST)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 2'd1;
                        state_reg <= ST_AX_START;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, loaded as the sequencer passes through each step.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    want_reg[0] <= want_roll;
                    want_reg[1] <= want_pitch;
                    want_reg[2] <= want_yaw;
                    meas_reg[0] <= meas_roll;
                    meas_reg[1] <= meas_pitch;
                    meas_reg[2] <= meas_yaw;
                end
            end
            ST_AX_START:
            begin
                err_reg  <= {want_reg[ax_reg][31], want_reg[ax_reg]}
                          - {meas_reg[ax_reg][31], meas_reg[ax_reg]};
                diff_reg <= {prev_reg[ax_reg][31], prev_reg[ax_reg]}
                          - {meas_reg[ax_reg][31], meas_reg[ax_reg]};
            end
            ST_LAUNCH:
            begin
                mul_a_reg   <= {err_reg[32], err_reg};
                mul_b_reg   <= {{(trp_pkg::MUL_W-PERIOD_W){1'b0}}, step_period_reg};
                div_num_reg <= {diff_mag, {FRAC_BITS{1'b0}}};
                div_neg_reg <= diff_reg[32];
            end
            ST_W_INC:
            begin
                if (mul_done)
                begin
                    acc_reg <= integ_ext + prod_shift;
                end
            end
            ST_CLAMP:
            begin
                mul_a_reg <= {{2{gain_prop_reg[31]}}, gain_prop_reg};
                mul_b_reg <= {err_reg[32], err_reg};
                tsum_reg  <= '0;
            end
            ST_W_P:
            begin
                if (mul_done)
                begin
                    tsum_reg  <= tsum_reg + prod_shift;
                    mul_a_reg <= {{2{gain_integ_reg[31]}}, gain_integ_reg};
                    mul_b_reg <= {{2{integ_reg[ax_reg][31]}}, integ_reg[ax_reg]};
                end
            end
            ST_W_I:
            begin
                if (mul_done)
                begin
                    tsum_reg <= tsum_reg + prod_shift;
                end
            end
            ST_W_DIV:
            begin
                mul_a_reg <= {{2{gain_deriv_reg[31]}}, gain_deriv_reg};
                mul_b_reg <= {{2{deriv[31]}}, deriv};
            end
            ST_W_D:
            begin
                if (mul_done)
                begin
                    tsum_reg <= tsum_reg + prod_shift;
                end
            end
            ST_SAT:
            begin
                tq_reg[ax_reg] <= tsum_sat;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    torque_reg[0] <= tq_reg[0];
                    torque_reg[1] <= tq_reg[1];
                    torque_reg[2] <= tq_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign torque_roll  = torque_reg[0];
    assign torque_pitch = torque_reg[1];
    assign torque_yaw   = torque_reg[2];

endmodule

[design/trp_booth_mul.sv]
module trp_booth_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  trp_pkg::trp_mul_op_t a,
    input  trp_pkg::trp_mul_op_t b,
    output logic               done,
    output trp_pkg::trp_prod_t prod
);

    localparam int HI_W  = trp_pkg::MUL_W + 2;
    localparam int CNT_W = $clog2(trp_pkg::MUL_STEPS + 1);

    logic                    busy_reg;
    logic                    done_reg;
    logic [CNT_W-1:0]        cnt_reg;
    trp_pkg::trp_mul_op_t    a_reg;
    logic signed [HI_W-1:0]  hi_reg;
    logic [trp_pkg::MUL_W-1:0] lo_reg;
    logic                    bm1_reg;

    logic signed [HI_W-1:0]  a_ext;
    logic signed [HI_W-1:0]  pp_mag;
    logic signed [HI_W-1:0]  pp;
    logic signed [HI_W-1:0]  sum;
    logic                    dig_neg;
    logic                    dig_one;
    logic                    dig_two;

    // Radix-4 Booth recoding of the two lowest multiplier bits and the bit below them.
    always_comb
    begin
        a_ext   = {{2{a_reg[trp_pkg::MUL_W-1]}}, a_reg};
        dig_neg = lo_reg[1];
        dig_one = lo_reg[0] ^ bm1_reg;
        dig_two = (lo_reg[1] & ~lo_reg[0] & ~bm1_reg) | (~lo_reg[1] & lo_reg[0] & bm1_reg);
        if (dig_two)
        begin
            pp_mag = a_ext <<< 1;
        end
        else if (dig_one)
        begin
            pp_mag = a_ext;
        end
        else
        begin
            pp_mag = '0;
        end
        pp  = dig_neg ? -pp_mag : pp_mag;
        sum = hi_reg + pp;
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(trp_pkg::MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial product shifts right two bits a cycle; the multiplier drains out below it.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            hi_reg  <= '0;
            lo_reg  <= b;
            bm1_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            hi_reg  <= sum >>> 2;
            lo_reg  <= {sum[1:0], lo_reg[trp_pkg::MUL_W-1:2]};
            bm1_reg <= lo_reg[1];
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[trp_pkg::MUL_W-1:0], lo_reg};

endmodule

[design/trp_serial_div.sv]
module trp_serial_div #(
    parameter int NUM_W = 49
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [trp_pkg::PERIOD_W-1:0]  den,
    output logic                          busy,
    output logic [NUM_W-1:0]              quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int REM_W = trp_pkg::PERIOD_W;

    logic                 busy_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     den_reg;

    logic [REM_W:0]       shifted;
    logic [REM_W:0]       trial;
    logic                 fits;

    // One restoring step: bring down the next numerator bit and try the subtraction.
    always_comb
    begin
        shifted = {rem_reg, q_reg[NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = shifted >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The numerator shifts out at the top while quotient bits shift in at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial[REM_W-1:0] : shifted[REM_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

[design/trp_checker.sv]
module trp_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [trp_pkg::DATA_W-1:0]  torque_roll,
    input logic signed [trp_pkg::DATA_W-1:0]  torque_pitch,
    input logic signed [trp_pkg::DATA_W-1:0]  torque_yaw
);

    // A result waiting on a stalled output holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(torque_roll)
            && $stable(torque_pitch) && $stable(torque_yaw))
        else $error("result changed or vanished while stalled");

    // Once an item is taken the block is busy with it on the next cycle.
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // No result can appear on the cycle straight after an input transfer.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too soon after input transfer");

    // A fresh result is presented only as the block returns to idle.
    a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result raised while the block is still busy");

endmodule

bind three_axis_rate_pid_unit trp_checker u_trp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .torque_roll  (torque_roll),
    .torque_pitch (torque_pitch),
    .torque_yaw   (torque_yaw)
);
